// File: design/deq_pkg.sv
// Package for the deadline event queue: request and result types,
// cell control struct, operation and kind codes, default sizes.
// No dependencies.
package deq_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int OBJECT_BITS_DEF = 8;
  localparam int OBJ_W           = 8;
  localparam int MAX_OBJ_BITS    = 16;
  localparam int DL_W            = 32;

  localparam logic FUNC_SCHEDULE = 1'b0;
  localparam logic FUNC_TICK     = 1'b1;

  localparam logic [1:0] KIND_SCHEDULED  = 2'd0;
  localparam logic [1:0] KIND_DROPPED    = 2'd1;
  localparam logic [1:0] KIND_DISPATCHED = 2'd2;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_SHIFT  = 2'd3;

  typedef struct packed {
    logic                   func;
    logic [OBJ_W-1:0]       object_id;
    logic signed [DL_W-1:0] delay;
    logic [DL_W-1:0]        tick_value;
  } deq_req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [OBJ_W-1:0] out_object;
    logic [DL_W-1:0]  out_deadline;
    logic             last;
  } deq_res_t;

  typedef struct packed {
    logic [1:0]              op;
    logic [MAX_OBJ_BITS-1:0] key;
    logic [DL_W-1:0]         new_dl;
  } deq_ctl_t;

endpackage

// File: design/deq_cell.sv
// One slot of the sorted queue: holds an entry and moves it to or from its
// neighbors on remove, insert and shift commands. Depends on deq_pkg.
module deq_cell #(
  parameter int OBJECT_BITS = deq_pkg::OBJECT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  deq_pkg::deq_ctl_t       ctl,
  input  logic                    left_valid,
  input  logic [OBJECT_BITS-1:0]  left_obj,
  input  logic [deq_pkg::DL_W-1:0] left_dl,
  input  logic                    left_here,
  input  logic                    right_valid,
  input  logic [OBJECT_BITS-1:0]  right_obj,
  input  logic [deq_pkg::DL_W-1:0] right_dl,
  input  logic                    flag_in,
  output logic                    valid,
  output logic [OBJECT_BITS-1:0]  obj,
  output logic [deq_pkg::DL_W-1:0] dl,
  output logic                    here,
  output logic                    flag_out
);
  import deq_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [OBJECT_BITS-1:0] obj_r, obj_nxt;
  logic [DL_W-1:0]        dl_r, dl_nxt;
  logic                   match;

  assign match    = valid_r && (obj_r == ctl.key[OBJECT_BITS-1:0]);
  assign flag_out = flag_in | match;
  assign here     = !valid_r || (ctl.new_dl <= dl_r);

  always_comb begin
    valid_nxt = valid_r;
    obj_nxt   = obj_r;
    dl_nxt    = dl_r;
    unique case (ctl.op)
      OP_HOLD: begin
      end
      OP_REMOVE: begin
        if (flag_out) begin
          valid_nxt = right_valid;
          obj_nxt   = right_obj;
          dl_nxt    = right_dl;
        end
      end
      OP_INSERT: begin
        if (here && !left_here) begin
          valid_nxt = 1'b1;
          obj_nxt   = ctl.key[OBJECT_BITS-1:0];
          dl_nxt    = ctl.new_dl;
        end else if (here) begin
          valid_nxt = left_valid;
          obj_nxt   = left_obj;
          dl_nxt    = left_dl;
        end
      end
      OP_SHIFT: begin
        valid_nxt = right_valid;
        obj_nxt   = right_obj;
        dl_nxt    = right_dl;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obj_r <= obj_nxt;
    dl_r  <= dl_nxt;
  end

  assign valid = valid_r;
  assign obj   = obj_r;
  assign dl    = dl_r;

endmodule

// File: design/deadline_event_queue.sv
// Top level of the deadline event queue: control sequencer, chain of
// deq_cell slots and output register. Depends on deq_pkg and deq_cell.
//
// Usage:
//   in_data carries one request (func, object_id, delay, tick_value) under
//   valid/ready; out_data carries results (kind, out_object, out_deadline,
//   last) under valid/ready. Entries stay sorted by ascending deadline in a
//   row of DEPTH cells; each cell compares itself against the request and
//   moves data to or from its neighbors in the same cycle.
//   Schedule: the accept cycle removes any old entry of the object (prefix
//   flag rippling down the cell row); S_INSERT then, once the output
//   register is free, inserts or drops and loads the single result.
//   Tick: the accept cycle captures tick_value; S_DISPATCH then dispatches
//   the head cell and shifts the row left once per cycle while the output
//   register is free, until the head is not due. A tick with nothing due
//   gives no result.
//   in_ready is high only while no request is in progress. A stalled
//   receiver holds the result in the output register and pauses the
//   sequencer until it is taken. Reset (rst_n low, synchronous) empties the
//   queue and the output register; no clearing pass is needed.
module deadline_event_queue #(
  parameter int DEPTH       = deq_pkg::DEPTH_DEF,
  parameter int OBJECT_BITS = deq_pkg::OBJECT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::deq_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output deq_pkg::deq_res_t out_data
);
  import deq_pkg::*;

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_INSERT   = 2'd1;
  localparam logic [1:0] S_DISPATCH = 2'd2;

  localparam logic [MAX_OBJ_BITS-1:0] OBJ_MASK =
    MAX_OBJ_BITS'((32'd1 << OBJECT_BITS) - 32'd1);

  logic [1:0]              state_r, state_nxt;
  logic [DL_W-1:0]         dl_r, dl_nxt;
  logic [MAX_OBJ_BITS-1:0] key_r, key_nxt;
  logic [DL_W-1:0]         tick_r, tick_nxt;
  logic                    out_valid_r, out_valid_nxt;
  deq_res_t                out_data_r, out_data_nxt;

  deq_ctl_t                ctl;
  logic                    accept;
  logic                    out_free;
  logic                    due0, due1;
  logic [MAX_OBJ_BITS-1:0] in_key;
  logic [MAX_OBJ_BITS-1:0] head_obj;

  logic [DEPTH-1:0]       valid_vec;
  logic [DEPTH-1:0]       here_vec;
  logic [DEPTH:0]         flag_chain;
  logic [OBJECT_BITS-1:0] cell_obj [DEPTH];
  logic [DL_W-1:0]        cell_dl  [DEPTH];

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_key   = MAX_OBJ_BITS'(in_data.object_id) & OBJ_MASK;
  assign head_obj = MAX_OBJ_BITS'(cell_obj[0]);
  assign due0     = valid_vec[0] && (cell_dl[0] <= tick_r);
  assign due1     = valid_vec[1] && (cell_dl[1] <= tick_r);

  assign flag_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   l_valid, l_here, r_valid;
    logic [OBJECT_BITS-1:0] l_obj, r_obj;
    logic [DL_W-1:0]        l_dl, r_dl;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_here  = 1'b0;
      assign l_obj   = '0;
      assign l_dl    = '0;
    end else begin : g_mid
      assign l_valid = valid_vec[i-1];
      assign l_here  = here_vec[i-1];
      assign l_obj   = cell_obj[i-1];
      assign l_dl    = cell_dl[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_obj   = '0;
      assign r_dl    = '0;
    end else begin : g_body
      assign r_valid = valid_vec[i+1];
      assign r_obj   = cell_obj[i+1];
      assign r_dl    = cell_dl[i+1];
    end

    deq_cell #(
      .OBJECT_BITS(OBJECT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_valid (l_valid),
      .left_obj   (l_obj),
      .left_dl    (l_dl),
      .left_here  (l_here),
      .right_valid(r_valid),
      .right_obj  (r_obj),
      .right_dl   (r_dl),
      .flag_in    (flag_chain[i]),
      .valid      (valid_vec[i]),
      .obj        (cell_obj[i]),
      .dl         (cell_dl[i]),
      .here       (here_vec[i]),
      .flag_out   (flag_chain[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    dl_nxt        = dl_r;
    key_nxt       = key_r;
    tick_nxt      = tick_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctl.op        = OP_HOLD;
    ctl.key       = key_r;
    ctl.new_dl    = dl_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.func == FUNC_SCHEDULE) begin
            ctl.op    = OP_REMOVE;
            ctl.key   = in_key;
            key_nxt   = in_key;
            dl_nxt    = in_data.tick_value + $unsigned(in_data.delay);
            state_nxt = S_INSERT;
          end else begin
            tick_nxt  = in_data.tick_value;
            state_nxt = S_DISPATCH;
          end
        end
      end
      S_INSERT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.out_object = key_r[OBJ_W-1:0];
          out_data_nxt.out_deadline = dl_r;
          out_data_nxt.last       = 1'b1;
          if (valid_vec[DEPTH-1]) begin
            out_data_nxt.kind = KIND_DROPPED;
          end else begin
            out_data_nxt.kind = KIND_SCHEDULED;
            ctl.op            = OP_INSERT;
          end
          state_nxt = S_IDLE;
        end
      end
      S_DISPATCH: begin
        if (!due0) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.kind         = KIND_DISPATCHED;
          out_data_nxt.out_object   = head_obj[OBJ_W-1:0];
          out_data_nxt.out_deadline = cell_dl[0];
          out_data_nxt.last         = !due1;
          ctl.op                    = OP_SHIFT;
          if (!due1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r       <= dl_nxt;
    key_r      <= key_nxt;
    tick_r     <= tick_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    else $error("queue entries not contiguous from the head");

  a_shift_due: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_SHIFT) |-> (state_r == S_DISPATCH && due0 && out_free))
    else $error("head shifted out while not due");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_INSERT) |-> !valid_vec[DEPTH-1])
    else $error("insert into a full queue");

  a_remove_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_REMOVE && flag_chain[DEPTH]) |=> !valid_vec[DEPTH-1])
    else $error("removal did not free the tail slot");

endmodule
